>>> src/plcs_pkg.sv
// ----------------------------------------------------------------------------
// plcs_pkg
// Shared types and constants of the piecewise linear contrast stretch.
// ----------------------------------------------------------------------------
`default_nettype none

package plcs_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned REM_W  = 18;
  localparam int unsigned DVS_W  = 9;
  localparam int unsigned CELLS  = PIX_W;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [IDX_W-1:0] REG_KNEE_LOW_IN   = 8'd0;
  localparam logic [IDX_W-1:0] REG_KNEE_HIGH_IN  = 8'd1;
  localparam logic [IDX_W-1:0] REG_KNEE_LOW_OUT  = 8'd2;
  localparam logic [IDX_W-1:0] REG_KNEE_HIGH_OUT = 8'd3;

  localparam logic [PIX_W-1:0] RST_KNEE_LOW_IN   = 8'd100;
  localparam logic [PIX_W-1:0] RST_KNEE_HIGH_IN  = 8'd200;
  localparam logic [PIX_W-1:0] RST_KNEE_LOW_OUT  = 8'd100;
  localparam logic [PIX_W-1:0] RST_KNEE_HIGH_OUT = 8'd150;

  typedef struct packed {
    logic [PIX_W-1:0] low_in;
    logic [PIX_W-1:0] high_in;
    logic [PIX_W-1:0] low_out;
    logic [PIX_W-1:0] high_out;
  } knees_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [PIX_W-1:0] quot;
    logic             frame_end;
  } cell_data_t;

endpackage

`default_nettype wire

>>> src/plcs_front.sv
// ----------------------------------------------------------------------------
// plcs_front
// Segment select, products and rounded dividend/divisor, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module plcs_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire plcs_pkg::knees_t           knees,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [plcs_pkg::PIX_W-1:0] in_pixel,
  input  wire logic                       in_frame_end,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output plcs_pkg::cell_data_t            out_data
);

  logic v0, v1, v2;
  logic rdy0, rdy1, rdy2;

  // stage 0: segment operands
  logic [7:0]        start0, off0, span0;
  logic signed [8:0] rise0;
  logic              fe0;
  logic [7:0]        start_next, off_next, span_next;
  logic signed [8:0] rise_next;

  // stage 1: products
  logic [15:0]        prod_a;
  logic signed [17:0] prod_b;
  logic [7:0]         span1;
  logic               fe1;

  logic signed [18:0] num_sum;
  logic [15:0]        num;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;
  assign out_valid = v2;

  always_comb begin
    if (in_pixel < knees.low_in) begin
      start_next = 8'd0;
      rise_next  = $signed({1'b0, knees.low_out});
      off_next   = in_pixel;
      span_next  = knees.low_in;
    end else if (in_pixel < knees.high_in) begin
      start_next = knees.low_out;
      rise_next  = $signed({1'b0, knees.high_out}) - $signed({1'b0, knees.low_out});
      off_next   = in_pixel - knees.low_in;
      span_next  = knees.high_in - knees.low_in;
    end else if (knees.high_in == plcs_pkg::PIX_MAX) begin
      // last knee at full scale gives the knee level
      start_next = knees.high_out;
      rise_next  = 9'sd0;
      off_next   = 8'd0;
      span_next  = 8'd1;
    end else begin
      start_next = knees.high_out;
      rise_next  = $signed({1'b0, plcs_pkg::PIX_MAX}) - $signed({1'b0, knees.high_out});
      off_next   = in_pixel - knees.high_in;
      span_next  = plcs_pkg::PIX_MAX - knees.high_in;
    end
  end

  assign num_sum = $signed({3'b000, prod_a}) + $signed({prod_b[17], prod_b});
  assign num     = num_sum[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      start0 <= start_next;
      rise0  <= rise_next;
      off0   <= off_next;
      span0  <= span_next;
      fe0    <= in_frame_end;
    end
    if (rdy1 && v0) begin
      prod_a <= start0 * span0;
      prod_b <= rise0 * $signed({1'b0, off0});
      span1  <= span0;
      fe1    <= fe0;
    end
    if (rdy2 && v1) begin
      out_data.rem       <= {1'b0, num, 1'b0} + {10'd0, span1};
      out_data.dvs       <= {span1, 1'b0};
      out_data.quot      <= '0;
      out_data.frame_end <= fe1;
    end
  end

endmodule

`default_nettype wire

>>> src/plcs_div_cell.sv
// ----------------------------------------------------------------------------
// plcs_div_cell
// One restoring division step, settles one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module plcs_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire plcs_pkg::cell_data_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output plcs_pkg::cell_data_t      out_data
);

  logic [plcs_pkg::REM_W-1:0] shifted;
  logic                       take;
  plcs_pkg::cell_data_t       data_next;

  assign in_ready = !out_valid || out_ready;
  assign shifted  = plcs_pkg::REM_W'(in_data.dvs) << BIT;
  assign take     = in_data.rem >= shifted;

  always_comb begin
    data_next = in_data;
    if (take) begin
      data_next.rem       = in_data.rem - shifted;
      data_next.quot[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> src/piecewise_linear_contrast_stretch.sv
// ----------------------------------------------------------------------------
// piecewise_linear_contrast_stretch
// Maps 8-bit grey pixels through a three-segment curve with two knees.
//
// s_* carries one pixel per request (s_tdata) with the end-of-frame mark on
// s_tlast; m_* returns the stretched pixel and the copied mark in order.
// cfg_* writes the knee registers: 0 low_in, 1 high_in, 2 low_out,
// 3 high_out; other indexes are ignored. cfg_ready is always high; write
// only while no pixel is in flight.
// Three front stages (segment select, products, rounded dividend) feed eight
// division cells, one quotient bit each. Throughput is one pixel per cycle
// while m_tready does not stall. Every stage has its own valid and a local
// ready, so a stalled m_tready holds the last cell while earlier stages keep
// filling; input stalls only once all 11 stages are full.
// Reset clears all stages and loads the knees (100,100) and (200,150).
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_contrast_stretch (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] pixel_in
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] pixel_out
  output logic            m_tlast,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  plcs_pkg::knees_t     knees;
  logic                 vld [plcs_pkg::CELLS+1];
  logic                 rdy [plcs_pkg::CELLS+1];
  plcs_pkg::cell_data_t dat [plcs_pkg::CELLS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      knees.low_in   <= plcs_pkg::RST_KNEE_LOW_IN;
      knees.high_in  <= plcs_pkg::RST_KNEE_HIGH_IN;
      knees.low_out  <= plcs_pkg::RST_KNEE_LOW_OUT;
      knees.high_out <= plcs_pkg::RST_KNEE_HIGH_OUT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        plcs_pkg::REG_KNEE_LOW_IN:   knees.low_in   <= cfg_data;
        plcs_pkg::REG_KNEE_HIGH_IN:  knees.high_in  <= cfg_data;
        plcs_pkg::REG_KNEE_LOW_OUT:  knees.low_out  <= cfg_data;
        plcs_pkg::REG_KNEE_HIGH_OUT: knees.high_out <= cfg_data;
        default: ;
      endcase
    end
  end

  plcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .knees        (knees),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_pixel     (s_tdata),
    .in_frame_end (s_tlast),
    .out_valid    (vld[0]),
    .out_ready    (rdy[0]),
    .out_data     (dat[0])
  );

  // most significant quotient bit first
  for (genvar i = 0; i < plcs_pkg::CELLS; i++) begin : g_cell
    plcs_div_cell #(
      .BIT (plcs_pkg::CELLS - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_data   (dat[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_data  (dat[i+1])
    );
  end

  assign rdy[plcs_pkg::CELLS] = m_tready;
  assign m_tvalid = vld[plcs_pkg::CELLS];
  assign m_tdata  = dat[plcs_pkg::CELLS].quot;
  assign m_tlast  = dat[plcs_pkg::CELLS].frame_end;

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream test of the piecewise linear contrast stretch: pixels go in through
// s_*, knees are set over cfg_* between phases while nothing is in flight,
// and every stretched pixel out of m_* is checked in order against a local
// model of the three-segment curve with half-up rounding.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned RAND_ITEMS  = 130;

  typedef struct {
    logic [7:0] pixel;
    logic       frame_end;
  } pix_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  pix_beat_t   pixel_feed[$];
  pix_beat_t   stretched_due[$];
  pix_beat_t   feed_beat;
  pix_beat_t   due_beat;
  knees_t      knees;
  int unsigned cyc_cnt = 0;
  int unsigned mismatch_cnt = 0;
  logic        in_taken = 1'b0;
  logic        calm;

  piecewise_linear_contrast_stretch u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign calm = (cyc_cnt[11:9] == 3'd5);

  function automatic knees_t make_knees(int a, int b, int c, int d);
    knees_t k;
    k.low_in   = a[7:0];
    k.high_in  = b[7:0];
    k.low_out  = c[7:0];
    k.high_out = d[7:0];
    return k;
  endfunction

  function automatic logic [7:0] stretch_level(logic [7:0] pix, knees_t k);
    int p, a, b, c, d, span, num;
    p = pix;
    a = k.low_in;
    b = k.high_in;
    c = k.low_out;
    d = k.high_out;
    if (p < a) begin
      num  = c * p;
      span = a;
    end else if (p < b) begin
      span = b - a;
      num  = c * span + (d - c) * (p - a);
    end else if (b >= 255) begin
      return d[7:0];
    end else begin
      span = 255 - b;
      num  = d * span + (255 - d) * (p - b);
    end
    num = (2 * num + span) / (2 * span);
    return num[7:0];
  endfunction

  function automatic int clip_level(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  task automatic queue_pixel(int pix, logic fe);
    pix_beat_t b;
    b.pixel     = pix[7:0];
    b.frame_end = fe;
    pixel_feed.push_back(b);
  endtask

  // pixels at the ends of the range and on both sides of each knee
  task automatic queue_knee_pixels(knees_t k);
    int lv [10];
    int a, b;
    a = k.low_in;
    b = k.high_in;
    lv = '{0, 1, a - 1, a, a + 1, b - 1, b, b + 1, 254, 255};
    foreach (lv[i]) begin
      queue_pixel(clip_level(lv[i]), (i % 3 == 2) || (i == 9));
    end
  endtask

  // frames of random length, pixels uniform or close to a knee
  task automatic queue_random_frames(knees_t k, int unsigned count);
    int unsigned left;
    int pix;
    left = $urandom_range(40, 1);
    repeat (count) begin
      case ($urandom_range(3))
        0:       pix = clip_level(int'(k.low_in) + $urandom_range(4) - 2);
        1:       pix = clip_level(int'(k.high_in) + $urandom_range(4) - 2);
        default: pix = $urandom_range(255);
      endcase
      left--;
      queue_pixel(pix, left == 0);
      if (left == 0) left = $urandom_range(40, 1);
    end
  endtask

  task automatic write_knees(knees_t k);
    logic [7:0] idx [5];
    logic [7:0] val [5];
    idx = '{8'($urandom_range(255, 4)), REG_KNEE_LOW_IN, REG_KNEE_HIGH_IN,
            REG_KNEE_LOW_OUT, REG_KNEE_HIGH_OUT};
    val = '{8'($urandom_range(255)), k.low_in, k.high_in, k.low_out, k.high_out};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_feed.size() != 0 || s_tvalid || stretched_due.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 38);
      if (!s_tvalid || in_taken) begin
        if (pixel_feed.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
          feed_beat = pixel_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= feed_beat.pixel;
          s_tlast  <= feed_beat.frame_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("[piecewise_linear_contrast_stretch] ERROR");
      $finish;
    end
    in_taken = !rst && s_tvalid && s_tready;
    if (rst) begin
      knees = make_knees(RST_KNEE_LOW_IN, RST_KNEE_HIGH_IN, RST_KNEE_LOW_OUT,
                         RST_KNEE_HIGH_OUT);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KNEE_LOW_IN:   knees.low_in   = cfg_data;
          REG_KNEE_HIGH_IN:  knees.high_in  = cfg_data;
          REG_KNEE_LOW_OUT:  knees.low_out  = cfg_data;
          REG_KNEE_HIGH_OUT: knees.high_out = cfg_data;
          default: ;
        endcase
      end
      if (in_taken) begin
        due_beat.pixel     = stretch_level(s_tdata, knees);
        due_beat.frame_end = s_tlast;
        stretched_due.push_back(due_beat);
      end
      if (m_tvalid && m_tready) begin
        if (stretched_due.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result: pixel %0d last %0b", m_tdata, m_tlast);
          mismatch_cnt++;
        end else begin
          due_beat = stretched_due.pop_front();
          if (m_tdata !== due_beat.pixel || m_tlast !== due_beat.frame_end) begin
            if (mismatch_cnt < 10)
              $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                       due_beat.pixel, due_beat.frame_end, m_tdata, m_tlast);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    knees_t plan [PHASES];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    plan[0] = make_knees(RST_KNEE_LOW_IN, RST_KNEE_HIGH_IN, RST_KNEE_LOW_OUT,
                         RST_KNEE_HIGH_OUT);
    plan[1] = make_knees(0, 128, 40, 200);     // first segment never taken
    plan[2] = make_knees(60, 255, 30, 90);     // last knee at full scale
    plan[3] = make_knees(200, 50, 180, 20);    // knees out of order
    plan[4] = make_knees(128, 128, 255, 255);  // single knee
    plan[5] = make_knees(0, 0, 0, 0);
    plan[6] = make_knees(255, 255, 255, 255);
    plan[7] = make_knees(50, 150, 220, 10);    // falling middle segment
    plan[8] = make_knees($urandom_range(255), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255));
    plan[9] = make_knees($urandom_range(127), $urandom_range(255, 128),
                         $urandom_range(255), $urandom_range(255));
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) write_knees(plan[ph]);
      queue_knee_pixels(plan[ph]);
      queue_random_frames(plan[ph], RAND_ITEMS);
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[piecewise_linear_contrast_stretch] OK");
    end else begin
      $display("[piecewise_linear_contrast_stretch] ERROR");
    end
    $finish;
  end

endmodule
